FILE: rtl/core/qet_pkg.sv
// Shared types, character constants and classification functions for the tokenizer.
package qet_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 8;

  localparam logic [CharW-1:0] ChEol    = 8'h00;
  localparam logic [CharW-1:0] ChQuote  = 8'h22;
  localparam logic [CharW-1:0] ChBslash = 8'h5C;
  localparam logic [CharW-1:0] ChLowT   = 8'h74;
  localparam logic [CharW-1:0] ChLowB   = 8'h62;
  localparam logic [CharW-1:0] ChLowN   = 8'h6E;
  localparam logic [CharW-1:0] ChLowR   = 8'h72;
  localparam logic [CharW-1:0] ChLowF   = 8'h66;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChBs     = 8'h08;
  localparam logic [CharW-1:0] ChLf     = 8'h0A;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChFf     = 8'h0C;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTilde  = 8'h7E;

  localparam logic [CountW-1:0] MaxTokensReset = 8'd16;

  // Scan mode, one-hot
  typedef enum logic [5:0] {
    MODE_BETWEEN   = 6'b000001,
    MODE_WORD      = 6'b000010,
    MODE_WORD_ESC  = 6'b000100,
    MODE_QUOTE     = 6'b001000,
    MODE_QUOTE_ESC = 6'b010000,
    MODE_DISCARD   = 6'b100000
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_NONPRINT = 2'd2,
    ST_UNCLOSED = 2'd3
  } status_e;

  // One result transaction
  typedef struct packed {
    logic [CharW-1:0]  out_char;
    logic              char_valid;
    logic [CountW-1:0] token_index;
    logic              token_start;
    logic              token_end;
    logic              done_res;
    status_e           status;
    logic [CountW-1:0] token_count;
  } res_t;

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_print(input logic [CharW-1:0] c);
    return (c >= ChSpace) && (c <= ChTilde);
  endfunction

  // Escape translation of the byte after a backslash
  function automatic logic [CharW-1:0] translate(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    case (c)
      ChLowT:  r = ChTab;
      ChLowB:  r = ChBs;
      ChLowN:  r = ChLf;
      ChLowR:  r = ChCr;
      ChLowF:  r = ChFf;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/qet_step.sv
// Next-mode and result logic for one character of the tokenizer.
module qet_step (
  input  qet_pkg::mode_e                    mode_i,
  input  logic [qet_pkg::CountW-1:0]        words_i,
  input  logic [qet_pkg::CountW-1:0]        max_tokens_i,
  input  logic [qet_pkg::CharW-1:0]         char_i,
  output qet_pkg::mode_e                    mode_o,
  output logic [qet_pkg::CountW-1:0]        words_o,
  output logic                              has_res_o,
  output qet_pkg::res_t                     res_o
);
  import qet_pkg::*;

  logic [CountW-1:0] words_inc;
  logic              limit_after;
  logic              c_eol, c_space, c_print;

  assign words_inc   = words_i + CountW'(1);
  assign limit_after = ({1'b0, words_i} + {{CountW{1'b0}}, 1'b1}) >= {1'b0, max_tokens_i};
  assign c_eol       = (char_i == ChEol);
  assign c_space     = is_space(char_i);
  assign c_print     = is_print(char_i);

  // Mode transition and result fields
  always_comb begin
    mode_o    = mode_i;
    words_o   = words_i;
    has_res_o = 1'b0;
    res_o     = '0;
    unique case (mode_i)
      MODE_BETWEEN: begin
        if (c_space) begin
          has_res_o = 1'b0;
        end else if (c_eol) begin
          has_res_o         = 1'b1;
          res_o.done_res    = 1'b1;
          res_o.status      = ST_OK;
          res_o.token_count = words_i;
          mode_o            = MODE_BETWEEN;
          words_o           = '0;
        end else if (words_i >= max_tokens_i) begin
          has_res_o      = 1'b1;
          res_o.done_res = 1'b1;
          res_o.status   = ST_TOO_MANY;
          mode_o         = MODE_DISCARD;
        end else if (char_i == ChQuote) begin
          has_res_o         = 1'b1;
          res_o.token_index = words_i;
          res_o.token_start = 1'b1;
          mode_o            = MODE_QUOTE;
        end else if (!c_print) begin
          has_res_o      = 1'b1;
          res_o.done_res = 1'b1;
          res_o.status   = ST_NONPRINT;
          mode_o         = MODE_DISCARD;
        end else if (char_i == ChBslash) begin
          has_res_o         = 1'b1;
          res_o.token_index = words_i;
          res_o.token_start = 1'b1;
          mode_o            = MODE_WORD_ESC;
        end else begin
          has_res_o         = 1'b1;
          res_o.out_char    = char_i;
          res_o.char_valid  = 1'b1;
          res_o.token_index = words_i;
          res_o.token_start = 1'b1;
          mode_o            = MODE_WORD;
        end
      end
      MODE_WORD: begin
        if (c_eol) begin
          has_res_o         = 1'b1;
          res_o.token_index = words_i;
          res_o.token_end   = 1'b1;
          res_o.done_res    = 1'b1;
          res_o.status      = ST_OK;
          res_o.token_count = words_inc;
          mode_o            = MODE_BETWEEN;
          words_o           = '0;
        end else if (c_space) begin
          has_res_o         = 1'b1;
          res_o.token_index = words_i;
          res_o.token_end   = 1'b1;
          words_o           = words_inc;
          mode_o            = MODE_BETWEEN;
        end else if (!c_print) begin
          has_res_o         = 1'b1;
          res_o.token_index = words_i;
          res_o.token_end   = 1'b1;
          res_o.done_res    = 1'b1;
          res_o.status      = limit_after ? ST_TOO_MANY : ST_NONPRINT;
          mode_o            = MODE_DISCARD;
        end else if (char_i == ChBslash) begin
          mode_o = MODE_WORD_ESC;
        end else begin
          has_res_o         = 1'b1;
          res_o.out_char    = char_i;
          res_o.char_valid  = 1'b1;
          res_o.token_index = words_i;
        end
      end
      MODE_WORD_ESC: begin
        has_res_o         = 1'b1;
        res_o.token_index = words_i;
        if (c_eol) begin
          res_o.token_end   = 1'b1;
          res_o.done_res    = 1'b1;
          res_o.status      = ST_OK;
          res_o.token_count = words_inc;
          mode_o            = MODE_BETWEEN;
          words_o           = '0;
        end else begin
          res_o.out_char   = translate(char_i);
          res_o.char_valid = 1'b1;
          mode_o           = MODE_WORD;
        end
      end
      MODE_QUOTE: begin
        if (c_eol) begin
          has_res_o      = 1'b1;
          res_o.done_res = 1'b1;
          res_o.status   = ST_UNCLOSED;
          mode_o         = MODE_BETWEEN;
          words_o        = '0;
        end else if (char_i == ChQuote) begin
          has_res_o         = 1'b1;
          res_o.token_index = words_i;
          res_o.token_end   = 1'b1;
          words_o           = words_inc;
          mode_o            = MODE_BETWEEN;
        end else if (!c_print) begin
          has_res_o      = 1'b1;
          res_o.done_res = 1'b1;
          res_o.status   = ST_NONPRINT;
          mode_o         = MODE_DISCARD;
        end else if (char_i == ChBslash) begin
          mode_o = MODE_QUOTE_ESC;
        end else begin
          has_res_o         = 1'b1;
          res_o.out_char    = char_i;
          res_o.char_valid  = 1'b1;
          res_o.token_index = words_i;
        end
      end
      MODE_QUOTE_ESC: begin
        has_res_o = 1'b1;
        if (c_eol) begin
          res_o.done_res = 1'b1;
          res_o.status   = ST_UNCLOSED;
          mode_o         = MODE_BETWEEN;
          words_o        = '0;
        end else begin
          res_o.out_char    = translate(char_i);
          res_o.char_valid  = 1'b1;
          res_o.token_index = words_i;
          mode_o            = MODE_QUOTE;
        end
      end
      MODE_DISCARD: begin
        // silent until line end
        if (c_eol) begin
          mode_o  = MODE_BETWEEN;
          words_o = '0;
        end
      end
      default: begin
        mode_o  = MODE_BETWEEN;
        words_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/qet_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
module qet_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  qet_pkg::res_t res_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          free_o,
  output qet_pkg::res_t res_o
);
  import qet_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Register can take a new result when empty or draining this cycle
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/core/quoted_escape_tokenizer.sv
// Top level of the quoted-word tokenizer: input register, scan state and result register.
// A character is held in the input register, and its result is then loaded into the result register.
// Throughput: one character per cycle while the result register can take each result; a full one stalls input.
// Characters that produce no result (spaces, backslashes, discarded bytes) still pass through the input register.
// Reset: scan state returns to between-words with zero words, max_tokens returns to 16,
// and both the input and result registers are emptied.
module quoted_escape_tokenizer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [qet_pkg::CountW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [qet_pkg::CharW-1:0]  char_code_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [qet_pkg::CharW-1:0]  out_char_o,
  output logic                       char_valid_o,
  output logic [qet_pkg::CountW-1:0] token_index_o,
  output logic                       token_start_o,
  output logic                       token_end_o,
  output logic                       done_res_o,
  output logic [1:0]                 status_o,
  output logic [qet_pkg::CountW-1:0] token_count_o
);
  import qet_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  logic [CharW-1:0]  s1_char_q;
  mode_e             mode_q, mode_d;
  logic [CountW-1:0] words_q, words_d;
  logic [CountW-1:0] max_q;
  logic              has_res, out_free, s1_adv;
  res_t              step_res, out_res;

  // Scan logic for the character held in the input register
  qet_step u_step (
    .mode_i       (mode_q),
    .words_i      (words_q),
    .max_tokens_i (max_q),
    .char_i       (s1_char_q),
    .mode_o       (mode_d),
    .words_o      (words_d),
    .has_res_o    (has_res),
    .res_o        (step_res)
  );

  qet_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_adv && has_res),
    .res_i       (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .res_o       (out_res)
  );

  // Input stage advances unless its result finds the output register full
  assign s1_adv     = s1_valid_q && (!has_res || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign s1_valid_d = (in_valid_i && in_ready_o) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      mode_q     <= MODE_BETWEEN;
      words_q    <= '0;
      max_q      <= MaxTokensReset;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        mode_q  <= mode_d;
        words_q <= words_d;
      end
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_char_q <= char_code_i;
    end
  end

  // Result fields
  assign out_char_o    = out_res.out_char;
  assign char_valid_o  = out_res.char_valid;
  assign token_index_o = out_res.token_index;
  assign token_start_o = out_res.token_start;
  assign token_end_o   = out_res.token_end;
  assign done_res_o    = out_res.done_res;
  assign status_o      = out_res.status;
  assign token_count_o = out_res.token_count;

  // Discarding never yields a result
  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (mode_q == MODE_DISCARD) |-> !has_res)
    else $error("result produced while discarding");

  // Error status carries no word count
  a_err_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o && (status_o != ST_OK) |-> (token_count_o == '0))
    else $error("error status with nonzero token count");

  // A word character is never a status result
  a_char_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_valid_o |-> !done_res_o)
    else $error("character result flagged as done");

  // A finished line leaves the scanner between words or discarding
  a_done_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && has_res && step_res.done_res
      |=> (mode_q == MODE_BETWEEN) || (mode_q == MODE_DISCARD))
    else $error("scanner mid-word after status result");

  // Output register cannot be overwritten while holding an untaken result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !(s1_adv && has_res))
    else $error("result register overwritten");

endmodule

FILE: sim/tokenizer_checker.sv
// Scoreboard for the quoted-word tokenizer: tracks scan state, predicts results and compares.
`timescale 1ns / 1ps
module tokenizer_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [qet_pkg::CountW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [qet_pkg::CharW-1:0]  char_code_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [qet_pkg::CharW-1:0]  out_char_i,
  input  logic                       char_valid_i,
  input  logic [qet_pkg::CountW-1:0] token_index_i,
  input  logic                       token_start_i,
  input  logic                       token_end_i,
  input  logic                       done_res_i,
  input  logic [1:0]                 status_i,
  input  logic [qet_pkg::CountW-1:0] token_count_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import qet_pkg::*;

  // Predicted tokenizer state and word limit
  mode_e             scan_q;
  logic [CountW-1:0] words_q;
  logic [CountW-1:0] limit_q;
  res_t              token_results_q[$];
  int                mismatches;

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_visible(input logic [CharW-1:0] c);
    return c inside {[8'h20:8'h7E]};
  endfunction

  // Byte after a backslash: five letters map to control codes
  function automatic logic [CharW-1:0] unescape(input logic [CharW-1:0] c);
    logic [CharW-1:0] code;
    code = c;
    if (c == ChLowT) code = ChTab;
    if (c == ChLowB) code = ChBs;
    if (c == ChLowN) code = ChLf;
    if (c == ChLowR) code = ChCr;
    if (c == ChLowF) code = ChFf;
    return code;
  endfunction

  // One character step; returns 1 when the character yields a result
  function automatic logic scan_char(input logic [CharW-1:0] c, output res_t r);
    logic [CountW:0] next_count;
    logic            emit;
    r = '0;
    emit = 1'b1;
    next_count = {1'b0, words_q} + 1'b1;
    case (scan_q)
      MODE_BETWEEN: begin
        if (is_blank(c)) begin
          emit = 1'b0;
        end else if (c == ChEol) begin
          r.done_res = 1'b1;
          r.token_count = words_q;
          words_q = '0;
        end else if (words_q >= limit_q) begin
          r.done_res = 1'b1;
          r.status = ST_TOO_MANY;
          scan_q = MODE_DISCARD;
        end else if (c == ChQuote) begin
          r.token_index = words_q;
          r.token_start = 1'b1;
          scan_q = MODE_QUOTE;
        end else if (!is_visible(c)) begin
          r.done_res = 1'b1;
          r.status = ST_NONPRINT;
          scan_q = MODE_DISCARD;
        end else if (c == ChBslash) begin
          r.token_index = words_q;
          r.token_start = 1'b1;
          scan_q = MODE_WORD_ESC;
        end else begin
          r.out_char = c;
          r.char_valid = 1'b1;
          r.token_index = words_q;
          r.token_start = 1'b1;
          scan_q = MODE_WORD;
        end
      end
      MODE_WORD, MODE_WORD_ESC: begin
        r.token_index = words_q;
        if (c == ChEol) begin
          // line end closes the unquoted word, even right after a backslash
          r.token_end = 1'b1;
          r.done_res = 1'b1;
          r.token_count = next_count[CountW-1:0];
          scan_q = MODE_BETWEEN;
          words_q = '0;
        end else if (scan_q == MODE_WORD_ESC) begin
          r.out_char = unescape(c);
          r.char_valid = 1'b1;
          scan_q = MODE_WORD;
        end else if (is_blank(c)) begin
          r.token_end = 1'b1;
          words_q = next_count[CountW-1:0];
          scan_q = MODE_BETWEEN;
        end else if (!is_visible(c)) begin
          // word still counts; reaching the limit wins over the bad byte
          r.token_end = 1'b1;
          r.done_res = 1'b1;
          r.status = (next_count >= {1'b0, limit_q}) ? ST_TOO_MANY : ST_NONPRINT;
          scan_q = MODE_DISCARD;
        end else if (c == ChBslash) begin
          emit = 1'b0;
          scan_q = MODE_WORD_ESC;
        end else begin
          r.out_char = c;
          r.char_valid = 1'b1;
        end
      end
      MODE_QUOTE, MODE_QUOTE_ESC: begin
        if (c == ChEol) begin
          r.done_res = 1'b1;
          r.status = ST_UNCLOSED;
          scan_q = MODE_BETWEEN;
          words_q = '0;
        end else if (scan_q == MODE_QUOTE_ESC) begin
          r.out_char = unescape(c);
          r.char_valid = 1'b1;
          r.token_index = words_q;
          scan_q = MODE_QUOTE;
        end else if (c == ChQuote) begin
          r.token_index = words_q;
          r.token_end = 1'b1;
          words_q = next_count[CountW-1:0];
          scan_q = MODE_BETWEEN;
        end else if (!is_visible(c)) begin
          r.done_res = 1'b1;
          r.status = ST_NONPRINT;
          scan_q = MODE_DISCARD;
        end else if (c == ChBslash) begin
          emit = 1'b0;
          scan_q = MODE_QUOTE_ESC;
        end else begin
          r.out_char = c;
          r.char_valid = 1'b1;
          r.token_index = words_q;
        end
      end
      default: begin
        // discarding until the line end, which restarts silently
        emit = 1'b0;
        if (c == ChEol) begin
          scan_q = MODE_BETWEEN;
          words_q = '0;
        end
      end
    endcase
    return emit;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t pred;
    if (!rst_ni) begin
      token_results_q.delete();
      scan_q = MODE_BETWEEN;
      words_q = '0;
      limit_q = MaxTokensReset;
      mismatches = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (token_results_q.size() == 0) begin
          $error("result transaction with none expected: out_char %0h done_res %0b",
                 out_char_i, done_res_i);
          mismatches++;
        end else begin
          want = token_results_q.pop_front();
          compare_field("out_char", want.out_char, out_char_i);
          compare_field("char_valid", want.char_valid, char_valid_i);
          compare_field("token_index", want.token_index, token_index_i);
          compare_field("token_start", want.token_start, token_start_i);
          compare_field("token_end", want.token_end, token_end_i);
          compare_field("done_res", want.done_res, done_res_i);
          compare_field("status", want.status, status_i);
          compare_field("token_count", want.token_count, token_count_i);
        end
      end
      if (cfg_we_i) begin
        limit_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (scan_char(char_code_i, pred)) begin
          token_results_q.push_back(pred);
        end
      end
      pending_o <= token_results_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: sim/testbench.sv
// Top of the tokenizer testbench: clock, reset, character stimulus, flow control and verdict.
`timescale 1ns / 1ps
module testbench;
  import qet_pkg::*;

  typedef logic [CharW-1:0] char_q_t[$];

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned TargetItems = 1900;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CountW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CharW-1:0]  char_code = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CharW-1:0]  out_char;
  logic              char_valid;
  logic [CountW-1:0] token_index;
  logic              token_start;
  logic              token_end;
  logic              done_res;
  logic [1:0]        status;
  logic [CountW-1:0] token_count;
  int                fail_count;
  int                pending;
  int                items_sent = 0;
  int                idle_cycles = 0;
  bit                steady = 1'b0;

  quoted_escape_tokenizer dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .char_code_i  (char_code),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_char_o   (out_char),
    .char_valid_o (char_valid),
    .token_index_o(token_index),
    .token_start_o(token_start),
    .token_end_o  (token_end),
    .done_res_o   (done_res),
    .status_o     (status),
    .token_count_o(token_count)
  );

  tokenizer_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .char_code_i  (char_code),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_char_i   (out_char),
    .char_valid_i (char_valid),
    .token_index_i(token_index),
    .token_start_i(token_start),
    .token_end_i  (token_end),
    .done_res_i   (done_res),
    .status_i     (status),
    .token_count_i(token_count),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Result side: random stall before each result, with stall-free stretches
  initial begin
    int stall;
    int free_left;
    free_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (free_left > 0) begin
        stall = 0;
        free_left--;
      end else begin
        stall = $urandom_range(0, 12);
        if ($urandom_range(0, 15) == 0) free_left = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // One character transaction, after a random gap unless the line runs steady
  task automatic send_char(input logic [CharW-1:0] c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_line(input char_q_t chars);
    foreach (chars[i]) send_char(chars[i]);
  endtask

  // Stop sending and let every outstanding result drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CountW-1:0] limit);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    char_q_t         line;
    int              nwords;
    int              len;
    int              pick;
    int              phase;
    int              phase_end;
    logic            quoted;
    logic            prev_quoted;
    logic [CharW-1:0] ch;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines at the reset word limit
    line = '{ChEol};
    send_line(line);
    // quote inside a word, escaped tab, empty quoted word, quote right after
    // a closing quote, escaped non-printable byte, backslash before line end
    line = '{"a", ChQuote, ChBslash, ChLowT, ChSpace, ChQuote, ChQuote, ChQuote,
             ChBslash, 8'hFF, ChQuote, ChBslash, ChEol};
    send_line(line);
    // backslash before line end inside quotes
    line = '{ChQuote, ChBslash, ChEol};
    send_line(line);
    // non-printable ends a word, rest of line discarded
    line = '{"~", 8'h80, "y", ChEol};
    send_line(line);

    // Limit of one word
    set_limit(8'd1);
    line = '{"b", 8'h7F, ChEol};
    send_line(line);
    line = '{"c", ChTab, "d", ChEol};
    send_line(line);

    // Random lines, word limit changed per phase
    phase = 0;
    while (items_sent < TargetItems) begin
      case (phase % 8)
        0: set_limit(8'd0);
        1: set_limit(8'd255);
        2: set_limit(8'd1);
        3: set_limit(8'd2);
        4: set_limit(8'($urandom_range(0, 255)));
        5: set_limit(8'd3);
        6: set_limit(MaxTokensReset);
        default: drain();
      endcase
      phase_end = items_sent + 220;
      while (items_sent < phase_end && items_sent < TargetItems) begin
        steady = ($urandom_range(0, 5) == 0);
        line.delete();
        prev_quoted = 1'b0;
        nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) line.push_back(ChSpace);
        for (int w = 0; w < nwords; w++) begin
          // separators; a quoted word may be followed directly by the next word
          if (w > 0 && !(prev_quoted && $urandom_range(0, 3) == 0)) begin
            repeat ($urandom_range(1, 3)) begin
              line.push_back(($urandom_range(0, 1) == 0) ? ChSpace : 8'($urandom_range(9, 13)));
            end
          end
          quoted = ($urandom_range(0, 2) == 0);
          len = quoted ? $urandom_range(0, 6) : $urandom_range(1, 6);
          if (quoted) line.push_back(ChQuote);
          for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
              line.push_back(ChBslash);
              case ($urandom_range(0, 5))
                0: line.push_back(ChLowT);
                1: line.push_back(ChLowB);
                2: line.push_back(ChLowN);
                3: line.push_back(ChLowR);
                4: line.push_back(ChLowF);
                default: line.push_back(8'($urandom_range(1, 255)));
              endcase
            end else if (quoted && pick < 20) begin
              line.push_back(ChSpace);
            end else begin
              ch = 8'($urandom_range(8'h21, 8'h7E));
              if (ch == ChBslash || (quoted && ch == ChQuote)) ch = "z";
              line.push_back(ch);
            end
          end
          if (quoted) line.push_back(ChQuote);
          prev_quoted = quoted;
        end
        if ($urandom_range(0, 3) == 0) line.push_back(ChSpace);
        // occasional broken line: dangling backslash, stray quote or noise byte
        case ($urandom_range(0, 19))
          0: line.push_back(ChBslash);
          1: line.push_back(ChQuote);
          2, 3: line.insert($urandom_range(0, line.size()), 8'($urandom_range(1, 255)));
          default: ;
        endcase
        line.push_back(ChEol);
        send_line(line);
      end
      phase++;
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
